FILE: rtl/assert_macros.svh
// Assertion macros for the framebuffer engine RTL.
// No dependencies; included inside module bodies that need checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/fpe_pkg.sv
// Shared types and constants for the framebuffer pixel engine.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package fpe_pkg;

  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 8;

  // Operation codes.
  localparam logic [3:0] OP_SET      = 4'd0;
  localparam logic [3:0] OP_CLEAR    = 4'd1;
  localparam logic [3:0] OP_TOGGLE   = 4'd2;
  localparam logic [3:0] OP_GET      = 4'd3;
  localparam logic [3:0] OP_CLR_AREA = 4'd4;
  localparam logic [3:0] OP_INV_AREA = 4'd5;
  localparam logic [3:0] OP_BLIT     = 4'd6;
  localparam logic [3:0] OP_CLR_ALL  = 4'd7;
  localparam logic [3:0] OP_INV_ALL  = 4'd8;

  // Column word update functions.
  localparam logic [1:0] FN_OR     = 2'd0;
  localparam logic [1:0] FN_ANDNOT = 2'd1;
  localparam logic [1:0] FN_XOR    = 2'd2;

  // Row mask shapes.
  localparam logic [1:0] MK_POINT = 2'd0;
  localparam logic [1:0] MK_SPAN  = 2'd1;
  localparam logic [1:0] MK_BYTE  = 2'd2;
  localparam logic [1:0] MK_FULL  = 2'd3;

  typedef struct packed {
    logic capture;
    logic decode;
    logic prep;
    logic issue;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_sweep;
    logic last;
  } sts_t;

endpackage

FILE: rtl/fpe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fpe_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/fpe_ctrl.sv
// Sequencing state machine for the framebuffer pixel engine.
// Depends on fpe_pkg for the command and status structs.
`timescale 1ns / 1ps

module fpe_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  output logic         m_tvalid,
  input  logic         m_tready,
  input  fpe_pkg::sts_t sts,
  output fpe_pkg::cmd_t cmd
);

  import fpe_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_PREP   = 3'd2;
  localparam logic [2:0] ST_SWEEP  = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.capture  = s_tvalid && s_tready;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        state_next = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = sts.need_sweep ? ST_SWEEP : ST_FINISH;
      end
      ST_SWEEP: begin
        cmd.issue = 1'b1;
        if (sts.last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/fpe_datapath.sv
// Datapath of the framebuffer pixel engine: operand decode, clipping,
// row mask build and the read-modify-write column sweep. Uses fpe_pkg and fpe_ram.
`timescale 1ns / 1ps

module fpe_datapath #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  fpe_pkg::cmd_t                    cmd,
  output fpe_pkg::sts_t                    sts,
  input  logic [fpe_pkg::S_TDATA_W-1:0]    s_tdata,
  output logic [fpe_pkg::M_TDATA_W-1:0]    m_tdata
);

  import fpe_pkg::*;

  localparam int CW = $clog2(SCREEN_WIDTH);
  localparam int RW = $clog2(SCREEN_HEIGHT);
  localparam int BW = SCREEN_HEIGHT + 16;
  localparam logic signed [17:0] W_LAST = 18'(SCREEN_WIDTH - 1);
  localparam logic signed [17:0] H_LAST = 18'(SCREEN_HEIGHT - 1);

  // Captured input item.
  logic [3:0]         op_q;
  logic signed [15:0] x_q;
  logic signed [15:0] y_q;
  logic [7:0]         w_q;
  logic [7:0]         h_q;
  logic [7:0]         byte_q;

  // Decode results.
  logic signed [17:0] xs, ys, xe, ye, yb, ax0, ax1, ay0, ay1;
  logic               pt_x_on, pt_on, area_on, blit_on;
  logic               d_on, d_sweep, d_clr_all, d_write, d_get;
  logic [1:0]         d_fn, d_kind;
  logic [CW-1:0]      d_lo, d_hi;
  logic [RW-1:0]      d_rlo, d_rhi;

  logic               on_q, sweep_q, clr_all_q, write_q, get_q;
  logic [1:0]         fn_q, kind_q;
  logic [CW-1:0]      c_lo, c_hi;
  logic [RW-1:0]      r_lo, r_hi;
  logic [6:0]         shift_q;

  // Mask and sweep.
  logic [SCREEN_HEIGHT-1:0] ones, mask_next, mask_q;
  logic [BW-1:0]            wide;
  logic [CW-1:0]            col, rd_col;
  logic                     rd_pend, vld_rd, we, pix_q;
  logic [SCREEN_WIDTH-1:0]  valid;
  logic [SCREEN_HEIGHT-1:0] rdata, old_word, new_word;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= s_tdata[3:0];
      x_q    <= s_tdata[19:4];
      y_q    <= s_tdata[35:20];
      w_q    <= s_tdata[43:36];
      h_q    <= s_tdata[51:44];
      byte_q <= s_tdata[59:52];
    end
  end

  // Edges are worked out in 18 bits so that an edge plus a size never wraps.
  always_comb begin
    xs      = 18'(x_q);
    ys      = 18'(y_q);
    xe      = xs + $signed({10'd0, w_q}) - 18'sd1;
    ye      = ys + $signed({10'd0, h_q}) - 18'sd1;
    yb      = ys + 18'sd7;
    ax0     = (xs < 18'sd0) ? 18'sd0 : xs;
    ax1     = (xe > W_LAST) ? W_LAST : xe;
    ay0     = (ys < 18'sd0) ? 18'sd0 : ys;
    ay1     = (ye > H_LAST) ? H_LAST : ye;
    pt_x_on = (xs >= 18'sd0) && (xs <= W_LAST);
    pt_on   = pt_x_on && (ys >= 18'sd0) && (ys <= H_LAST);
    area_on = (w_q != 8'd0) && (h_q != 8'd0) && (ax0 <= ax1) && (ay0 <= ay1);
    blit_on = pt_x_on && (yb >= 18'sd0) && (ys <= H_LAST);

    d_on      = 1'b0;
    d_sweep   = 1'b0;
    d_clr_all = 1'b0;
    d_write   = 1'b0;
    d_get     = 1'b0;
    d_fn      = FN_OR;
    d_kind    = MK_POINT;
    d_lo      = xs[CW-1:0];
    d_hi      = xs[CW-1:0];
    d_rlo     = ys[RW-1:0];
    d_rhi     = ys[RW-1:0];
    case (op_q)
      OP_SET, OP_CLEAR, OP_TOGGLE, OP_GET: begin
        d_on    = pt_on;
        d_sweep = pt_on;
        d_get   = (op_q == OP_GET);
        d_write = (op_q != OP_GET);
        d_fn    = (op_q == OP_CLEAR) ? FN_ANDNOT :
                  (op_q == OP_TOGGLE) ? FN_XOR : FN_OR;
      end
      OP_CLR_AREA, OP_INV_AREA: begin
        d_on    = area_on;
        d_sweep = area_on;
        d_write = 1'b1;
        d_fn    = (op_q == OP_CLR_AREA) ? FN_ANDNOT : FN_XOR;
        d_kind  = MK_SPAN;
        d_lo    = ax0[CW-1:0];
        d_hi    = ax1[CW-1:0];
        d_rlo   = ay0[RW-1:0];
        d_rhi   = ay1[RW-1:0];
      end
      OP_BLIT: begin
        d_on    = blit_on;
        d_sweep = blit_on;
        d_write = 1'b1;
        d_kind  = MK_BYTE;
      end
      OP_CLR_ALL: begin
        d_on      = 1'b1;
        d_clr_all = 1'b1;
      end
      OP_INV_ALL: begin
        d_on    = 1'b1;
        d_sweep = 1'b1;
        d_write = 1'b1;
        d_fn    = FN_XOR;
        d_kind  = MK_FULL;
        d_lo    = '0;
        d_hi    = CW'(SCREEN_WIDTH - 1);
      end
      default: begin
        d_on = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      on_q      <= d_on;
      sweep_q   <= d_sweep;
      clr_all_q <= d_clr_all;
      write_q   <= d_write;
      get_q     <= d_get;
      fn_q      <= d_fn;
      kind_q    <= d_kind;
      c_lo      <= d_lo;
      c_hi      <= d_hi;
      r_lo      <= d_rlo;
      r_hi      <= d_rhi;
      shift_q   <= yb[6:0];
    end
  end

  // Blit rows: row r of the byte lands at bit y + r + 7 of the shifted word,
  // so rows above the screen fall off the bottom of the select.
  always_comb begin
    ones = '1;
    wide = BW'(byte_q) << shift_q;
    case (kind_q)
      MK_POINT: mask_next = {{(SCREEN_HEIGHT-1){1'b0}}, 1'b1} << r_lo;
      MK_SPAN:  mask_next = (ones << r_lo) & (ones >> (RW'(SCREEN_HEIGHT - 1) - r_hi));
      MK_BYTE:  mask_next = wide[7 +: SCREEN_HEIGHT];
      MK_FULL:  mask_next = ones;
      default:  mask_next = ones;
    endcase
  end

  // A column that was never written since reset or clear-all reads as zero.
  always_comb begin
    old_word = vld_rd ? rdata : '0;
    case (fn_q)
      FN_OR:     new_word = old_word | mask_q;
      FN_ANDNOT: new_word = old_word & ~mask_q;
      FN_XOR:    new_word = old_word ^ mask_q;
      default:   new_word = old_word;
    endcase
  end

  assign we = rd_pend && write_q;

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      mask_q <= mask_next;
      col    <= c_lo;
    end else if (cmd.issue) begin
      col <= col + CW'(1);
    end
    if (cmd.issue) begin
      rd_col <= col;
      vld_rd <= valid[col];
    end
    if (cmd.prep) begin
      pix_q <= 1'b0;
    end else if (rd_pend && get_q) begin
      pix_q <= old_word[r_lo];
    end
    if (cmd.load_out) begin
      m_tdata <= {6'd0, on_q, pix_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      valid   <= '0;
    end else begin
      rd_pend <= cmd.issue;
      if (cmd.prep && clr_all_q) begin
        valid <= '0;
      end else if (we) begin
        valid[rd_col] <= 1'b1;
      end
    end
  end

  fpe_ram #(
    .WIDTH(SCREEN_HEIGHT),
    .DEPTH(SCREEN_WIDTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(rd_col),
    .wdata(new_word),
    .re   (cmd.issue),
    .raddr(col),
    .rdata(rdata)
  );

  assign sts.need_sweep = sweep_q;
  assign sts.last       = (col == c_hi);

endmodule

FILE: rtl/mono_framebuffer_pixel_engine_core.sv
// Top level of the monochrome framebuffer pixel engine.
// Depends on fpe_pkg, fpe_ctrl, fpe_datapath (with fpe_ram) and assert_macros.svh.
`timescale 1ns / 1ps

// The engine holds a SCREEN_WIDTH x SCREEN_HEIGHT one-bit image, one memory word
// per column, and takes one operation item at a time. Every item returns exactly
// one result item. An operation that touches columns runs a read-modify-write
// sweep over the column memory, one column per cycle: one column for pixel and
// blit operations, up to SCREEN_WIDTH for areas and invert all. Clear all and any
// item that touches no column (an off-screen point, an empty or off-screen area
// or blit, an unused code) skip the sweep. The result side can hold the engine:
// a new result waits in the last step until the previous one has been taken. The
// image reads as all dark after reset without a clearing pass: per-column valid
// flags stand in for the memory contents until a column is first written.

module mono_framebuffer_pixel_engine_core #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // op[3:0], x[19:4], y[35:20], width[43:36], height[51:44],
  // image_byte[59:52], zero fill[63:60]
  input  logic [fpe_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // pixel_value[0], on_screen[1], zero fill[7:2]
  output logic [fpe_pkg::M_TDATA_W-1:0] m_tdata
);

  import fpe_pkg::*;

  `include "assert_macros.svh"

  cmd_t cmd;
  sts_t sts;

  fpe_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  fpe_datapath #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .sts    (sts),
    .s_tdata(s_tdata),
    .m_tdata(m_tdata)
  );

  // Only one item is in flight: the engine drops ready straight after an accept.
  `ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  // A lit pixel can only be reported for a point on screen.
  `ASSERT_NOW(a_pixel_on_screen, m_tvalid && m_tdata[0], m_tdata[1])
  // A new result never overwrites one that is still waiting.
  `ASSERT_NOW(a_no_overwrite, cmd.load_out, !m_tvalid || m_tready)

endmodule
